// ===== sv/xxh_pkg.sv =====
// Shared constants, types and helpers of the streaming XXH64 hasher.
package xxh_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;
  localparam logic [63:0] P5 = 64'd2870177450012600261;

  // One classified input item: count is already saturated, eight when not last
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        last;
  } item_t;

  // Request to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LANE1,
    ST_LANE2,
    ST_FIN,
    ST_LEN,
    ST_MRG1,
    ST_MRG2,
    ST_MRG3,
    ST_TAIL1,
    ST_TAIL2,
    ST_TAIL3,
    ST_QUAD1,
    ST_QUAD2,
    ST_BYTE1,
    ST_BYTE2,
    ST_AVA1,
    ST_AVA2,
    ST_OUT
  } bst_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int s);
    return (x << s) | (x >> (64 - s));
  endfunction

endpackage

// ===== sv/xxh_front.sv =====
// Input side: classifies items and queues them for the hash engine.
module xxh_front import xxh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last,
  output logic        in_full,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       q_mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       item;
  logic        push_ok;
  logic        pop_ok;

  // Classify: saturate the count on the last item, force eight otherwise
  always_comb begin
    item.word = in_data_word;
    item.last = in_last;
    if (!in_last) begin
      item.cnt = 4'd8;
    end else if (in_byte_count > 4'd8) begin
      item.cnt = 4'd8;
    end else begin
      item.cnt = in_byte_count;
    end
  end

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_mem_r[rd_ptr_r];
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && q_valid;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the transfer
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== sv/xxh_mul.sv =====
// Shared 64x64 low-half multiplier built from one 32x32 multiplier, reused for each half product.
module xxh_mul import xxh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mul_req_t    req,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] x;
  logic [31:0] y;
  logic [63:0] pp;

  // Pick the half products: lo*lo, lo*hi, hi*lo
  always_comb begin
    case (step_r)
      2'd0:    begin x = a_r[31:0];  y = b_r[31:0];  end
      2'd1:    begin x = a_r[31:0];  y = b_r[63:32]; end
      default: begin x = a_r[63:32]; y = b_r[31:0];  end
    endcase
    pp = x * y;
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      if (step_r == 2'd0) begin
        acc_nxt = pp;
      end else begin
        acc_nxt = acc_r + {pp[31:0], 32'd0};
      end
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      a_nxt    = req.a;
      b_nxt    = req.b;
      step_nxt = 2'd0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== sv/xxh_back.sv =====
// Hash engine: stripe rounds, finalization sequence and the digest register.
module xxh_back import xxh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] seed,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output mul_req_t    mul_req,
  input  logic        mul_done,
  input  logic [63:0] mul_prod,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [63:0] out_digest
);

  bst_t        state_r, state_nxt;
  logic        issued_r, issued_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [1:0]  nbuf_r, nbuf_nxt;
  logic [63:0] len_r, len_nxt;
  logic        seen_r, seen_nxt;
  logic        last_r, last_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] word_r, word_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] tmp_r, tmp_nxt;
  logic [63:0] acc_r [4];
  logic [63:0] acc_nxt [4];
  logic [63:0] buf_r [4];
  logic [63:0] buf_nxt [4];
  logic [63:0] digest_r, digest_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        mul_state;
  logic        stripe;
  bst_t        after_tail;
  bst_t        after_words;

  // Where to go once the buffered words are folded
  always_comb begin
    if (cnt_r >= 4'd4) begin
      after_tail = ST_QUAD1;
    end else if (cnt_r != 4'd0) begin
      after_tail = ST_BYTE1;
    end else begin
      after_tail = ST_AVA1;
    end
    after_words = (nbuf_r != 2'd0) ? ST_TAIL1 : after_tail;
  end

  // Multiplier operands per state
  always_comb begin
    mul_state = 1'b1;
    mul_req.a = 64'd0;
    mul_req.b = 64'd0;
    unique case (state_r)
      ST_LANE1: begin mul_req.a = buf_r[idx_r];              mul_req.b = P2; end
      ST_LANE2: begin mul_req.a = tmp_r;                     mul_req.b = P1; end
      ST_MRG1:  begin mul_req.a = acc_r[idx_r];              mul_req.b = P2; end
      ST_MRG2:  begin mul_req.a = tmp_r;                     mul_req.b = P1; end
      ST_MRG3:  begin mul_req.a = h_r;                       mul_req.b = P1; end
      ST_TAIL1: begin mul_req.a = buf_r[idx_r];              mul_req.b = P2; end
      ST_TAIL2: begin mul_req.a = tmp_r;                     mul_req.b = P1; end
      ST_TAIL3: begin mul_req.a = rotl64(h_r, 27);           mul_req.b = P1; end
      ST_QUAD1: begin mul_req.a = {32'd0, word_r[31:0]};     mul_req.b = P1; end
      ST_QUAD2: begin mul_req.a = rotl64(h_r, 23);           mul_req.b = P2; end
      ST_BYTE1: begin
        mul_req.a = {56'd0, word_r[{pos_r, 3'b000} +: 8]};
        mul_req.b = P5;
      end
      ST_BYTE2: begin mul_req.a = rotl64(h_r, 11);           mul_req.b = P1; end
      ST_AVA1:  begin mul_req.a = h_r ^ (h_r >> 33);         mul_req.b = P2; end
      ST_AVA2:  begin mul_req.a = h_r ^ (h_r >> 29);         mul_req.b = P3; end
      default:  mul_state = 1'b0;
    endcase
    mul_req.start = mul_state && !issued_r;
  end

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    nbuf_nxt      = nbuf_r;
    len_nxt       = len_r;
    seen_nxt      = seen_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    word_nxt      = word_r;
    h_nxt         = h_r;
    tmp_nxt       = tmp_r;
    acc_nxt       = acc_r;
    buf_nxt       = buf_r;
    digest_nxt    = digest_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    stripe        = 1'b0;
    issued_nxt    = issued_r;
    if (mul_req.start) begin
      issued_nxt = 1'b1;
    end
    if (mul_done) begin
      issued_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          word_nxt = q_item.word;
          last_nxt = q_item.last;
          pos_nxt  = 3'd0;
          len_nxt  = len_r + {60'd0, q_item.cnt};
          if (q_item.cnt == 4'd8) begin
            // Buffer a full word
            buf_nxt[nbuf_r] = q_item.word;
            nbuf_nxt        = nbuf_r + 2'd1;
            stripe          = (nbuf_r == 2'd3);
            cnt_nxt         = 4'd0;
          end else begin
            cnt_nxt = q_item.cnt;
          end
          if (stripe) begin
            if (!seen_r) begin
              acc_nxt[0] = seed + P1 + P2;
              acc_nxt[1] = seed + P2;
              acc_nxt[2] = seed;
              acc_nxt[3] = seed - P1;
              seen_nxt   = 1'b1;
            end
            idx_nxt   = 2'd0;
            state_nxt = ST_LANE1;
          end else if (q_item.last) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_LANE1: begin
        if (mul_done) begin
          tmp_nxt   = rotl64(acc_r[idx_r] + mul_prod, 31);
          state_nxt = ST_LANE2;
        end
      end
      ST_LANE2: begin
        if (mul_done) begin
          acc_nxt[idx_r] = mul_prod;
          idx_nxt        = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            state_nxt = last_r ? ST_FIN : ST_IDLE;
          end else begin
            state_nxt = ST_LANE1;
          end
        end
      end
      ST_FIN: begin
        // Start from the merged lanes or from the seed
        if (seen_r) begin
          h_nxt = rotl64(acc_r[0], 1) + rotl64(acc_r[1], 7) +
                  rotl64(acc_r[2], 12) + rotl64(acc_r[3], 18);
          idx_nxt   = 2'd0;
          state_nxt = ST_MRG1;
        end else begin
          h_nxt     = seed + P5;
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        // Add the byte length once the lanes, if any, are merged
        h_nxt     = h_r + len_r;
        idx_nxt   = 2'd0;
        state_nxt = after_words;
      end
      ST_MRG1: begin
        if (mul_done) begin
          tmp_nxt   = rotl64(mul_prod, 31);
          state_nxt = ST_MRG2;
        end
      end
      ST_MRG2: begin
        if (mul_done) begin
          h_nxt     = h_r ^ mul_prod;
          state_nxt = ST_MRG3;
        end
      end
      ST_MRG3: begin
        if (mul_done) begin
          h_nxt     = mul_prod + P4;
          idx_nxt   = idx_r + 2'd1;
          state_nxt = (idx_r == 2'd3) ? ST_LEN : ST_MRG1;
        end
      end
      ST_TAIL1: begin
        if (mul_done) begin
          tmp_nxt   = rotl64(mul_prod, 31);
          state_nxt = ST_TAIL2;
        end
      end
      ST_TAIL2: begin
        if (mul_done) begin
          h_nxt     = h_r ^ mul_prod;
          state_nxt = ST_TAIL3;
        end
      end
      ST_TAIL3: begin
        if (mul_done) begin
          h_nxt   = mul_prod + P4;
          idx_nxt = idx_r + 2'd1;
          if (2'(idx_r + 2'd1) == nbuf_r) begin
            state_nxt = after_tail;
          end else begin
            state_nxt = ST_TAIL1;
          end
        end
      end
      ST_QUAD1: begin
        if (mul_done) begin
          h_nxt     = h_r ^ mul_prod;
          state_nxt = ST_QUAD2;
        end
      end
      ST_QUAD2: begin
        if (mul_done) begin
          h_nxt     = mul_prod + P3;
          pos_nxt   = 3'd4;
          state_nxt = (cnt_r > 4'd4) ? ST_BYTE1 : ST_AVA1;
        end
      end
      ST_BYTE1: begin
        if (mul_done) begin
          h_nxt     = h_r ^ mul_prod;
          state_nxt = ST_BYTE2;
        end
      end
      ST_BYTE2: begin
        if (mul_done) begin
          h_nxt   = mul_prod;
          pos_nxt = pos_r + 3'd1;
          if (4'({1'b0, pos_r} + 4'd1) == cnt_r) begin
            state_nxt = ST_AVA1;
          end else begin
            state_nxt = ST_BYTE1;
          end
        end
      end
      ST_AVA1: begin
        if (mul_done) begin
          h_nxt     = mul_prod;
          state_nxt = ST_AVA2;
        end
      end
      ST_AVA2: begin
        if (mul_done) begin
          h_nxt     = mul_prod;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // Load the digest once the result slot is free, then drop the message
        if (!out_valid_r || out_pop) begin
          digest_nxt    = h_r ^ (h_r >> 32);
          out_valid_nxt = 1'b1;
          nbuf_nxt      = 2'd0;
          len_nxt       = 64'd0;
          seen_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      nbuf_r      <= 2'd0;
      len_r       <= 64'd0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      nbuf_r      <= nbuf_nxt;
      len_r       <= len_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    last_r   <= last_nxt;
    cnt_r    <= cnt_nxt;
    word_r   <= word_nxt;
    h_r      <= h_nxt;
    tmp_r    <= tmp_nxt;
    acc_r    <= acc_nxt;
    buf_r    <= buf_nxt;
    digest_r <= digest_nxt;
  end

  assign out_empty  = !out_valid_r;
  assign out_digest = digest_r;

endmodule

// ===== sv/xxh64_stream_hash_top.sv =====
// Streaming XXH64 hasher: seed register, input queue, shared multiplier, hash engine.
// Each 64-bit multiply makes three 32x32 passes on the shared unit.
// Each completed stripe costs 8 multiplies; the engine takes no new word until they finish.
// Message end: 4 lane merges if a stripe ran, tail folds, 2 avalanche multiplies, digest.
// Synchronous active-low reset empties both queues and clears the message state and seed.
module xxh64_stream_hash_top import xxh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_push,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_digest
);

  logic [63:0] seed_r, seed_nxt;
  logic        q_valid;
  item_t       q_item;
  logic        q_pop;
  mul_req_t    mul_req;
  logic        mul_done;
  logic [63:0] mul_prod;

  // Hold the seed until written
  assign seed_nxt = cfg_wr_en ? cfg_wr_data : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 64'd0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  xxh_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .in_full       (in_full),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  xxh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  xxh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed       (seed_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .mul_req    (mul_req),
    .mul_done   (mul_done),
    .mul_prod   (mul_prod),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_digest (out_digest)
  );

  // Engine takes items only when the queue holds one
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("engine popped an empty queue");

  // No new multiply starts in the cycle the previous one retires
  a_mul_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> !mul_req.start)
    else $error("multiply issued while previous one retires");

  // Result side is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("result present after reset");

endmodule
